// ===== rtl/iirl_pkg.sv =====
// Package for the indexed insert/remove list: sizes, codes and the item types.
// Used by iirl_cell and indexed_insert_remove_list; depends on nothing else.
package iirl_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 4;
  localparam int COUNT_W  = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_DUMP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_ELEM  = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t        cmd;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] last_idx;
  } cell_ctrl_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [4:0]         position;
    logic signed [31:0] value;
  } iirl_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic [3:0]         element_index;
    logic [4:0]         count;
    logic               last;
  } iirl_resp_t;

endpackage

// ===== rtl/iirl_cell.sv =====
// One storage cell of the list chain: holds one element and takes it from
// its left or right neighbor on insert, remove and rotate. Uses iirl_pkg.
module iirl_cell (
  input  logic                          clk,
  input  iirl_pkg::cell_ctrl_t          ctrl,
  input  logic [iirl_pkg::IDX_W-1:0]    cell_index,
  input  logic signed [iirl_pkg::DATA_W-1:0] value,
  input  logic signed [iirl_pkg::DATA_W-1:0] left,
  input  logic signed [iirl_pkg::DATA_W-1:0] right,
  input  logic signed [iirl_pkg::DATA_W-1:0] head,
  output logic signed [iirl_pkg::DATA_W-1:0] data
);
  import iirl_pkg::*;

  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      CELL_INSERT: begin
        if (cell_index > ctrl.pos) begin
          data <= left;
        end else if (cell_index == ctrl.pos) begin
          data <= value;
        end
      end
      CELL_REMOVE: begin
        if (cell_index >= ctrl.pos) begin
          data <= right;
        end
      end
      CELL_ROTATE: begin
        // The occupied part of the chain turns by one place; the head wraps
        // around to the last occupied cell.
        if (cell_index == ctrl.last_idx) begin
          data <= head;
        end else if (cell_index < ctrl.last_idx) begin
          data <= right;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/indexed_insert_remove_list.sv =====
// Indexed insert/remove list: top level with the command decoder, the element
// count, the dump sequencer and the row of iirl_cell. Uses iirl_pkg.
//
// Usage:
//   A request item (operation, position, value) is taken at a rising edge
//   where start is high and busy is low. Results appear on response for one
//   cycle each, marked by strobe, starting the cycle after the item is taken.
//   The receiver cannot hold results off.
//   Insert, remove and clear give one result in the next cycle and leave busy
//   low, so a new item can be taken every cycle; the whole row of cells
//   shifts in parallel.
//   Dump of n elements gives n results on consecutive cycles, the final one
//   with last set; if n > 1, busy is high until the final result. The
//   elements are read from the head cell while the occupied cells rotate by
//   one place a cycle, so at the end of the dump the list is back in order.
//   A dump of an empty list gives one result with status empty.
//   Reset (synchronous, active high) empties the list and drops strobe and
//   busy; stored words are not cleared, only the count.
module indexed_insert_remove_list (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  iirl_pkg::iirl_req_t   request,
  output logic                  busy,
  output logic                  strobe,
  output iirl_pkg::iirl_resp_t  response
);
  import iirl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t               state, state_next;
  logic [COUNT_W-1:0]   count, count_next;
  logic [IDX_W-1:0]     dump_idx, dump_idx_next;
  iirl_resp_t           resp_next;
  logic                 strobe_next;
  logic                 accept;
  logic                 full;
  logic [IDX_W-1:0]     last_idx;
  logic [IDX_W-1:0]     ins_pos;
  logic [IDX_W-1:0]     rem_pos;
  cell_ctrl_t           cell_ctrl;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic signed [DATA_W-1:0] left_in   [CAPACITY];
  logic signed [DATA_W-1:0] right_in  [CAPACITY];

  assign busy     = (state == S_DUMP);
  assign accept   = start && !busy;
  assign full     = (count == COUNT_W'(CAPACITY));
  assign last_idx = IDX_W'(count - COUNT_W'(1));

  // Positions past the end mean the end of the list.
  assign ins_pos = (request.position > count) ? IDX_W'(count)
                                              : IDX_W'(request.position);
  assign rem_pos = (request.position >= count) ? last_idx
                                               : IDX_W'(request.position);

  always_comb begin
    cell_ctrl.cmd      = CELL_HOLD;
    cell_ctrl.pos      = '0;
    cell_ctrl.last_idx = last_idx;
    if (state == S_DUMP) begin
      cell_ctrl.cmd = CELL_ROTATE;
    end else if (accept) begin
      unique case (request.operation)
        OP_INSERT: begin
          if (!full) begin
            cell_ctrl.cmd = CELL_INSERT;
            cell_ctrl.pos = ins_pos;
          end
        end
        OP_REMOVE: begin
          if (count != '0) begin
            cell_ctrl.cmd = CELL_REMOVE;
            cell_ctrl.pos = rem_pos;
          end
        end
        OP_DUMP: begin
          if (count != '0) begin
            cell_ctrl.cmd = CELL_ROTATE;
          end
        end
        OP_CLEAR: begin
        end
      endcase
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_in[g] = request.value;
    end else begin : g_inner_l
      assign left_in[g] = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_final
      assign right_in[g] = cell_data[0];
    end else begin : g_inner_r
      assign right_in[g] = cell_data[g+1];
    end

    iirl_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .cell_index (IDX_W'(g)),
      .value      (request.value),
      .left       (left_in[g]),
      .right      (right_in[g]),
      .head       (cell_data[0]),
      .data       (cell_data[g])
    );
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    dump_idx_next = dump_idx;
    strobe_next   = 1'b0;
    resp_next     = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          strobe_next    = 1'b1;
          resp_next.last = 1'b1;
          unique case (request.operation)
            OP_INSERT: begin
              if (full) begin
                resp_next.status = STAT_FULL;
              end else begin
                resp_next.status = STAT_DONE;
                count_next       = count + COUNT_W'(1);
              end
            end
            OP_REMOVE: begin
              if (count == '0) begin
                resp_next.status = STAT_EMPTY;
              end else begin
                resp_next.status = STAT_DONE;
                count_next       = count - COUNT_W'(1);
              end
            end
            OP_CLEAR: begin
              resp_next.status = STAT_DONE;
              count_next       = '0;
            end
            OP_DUMP: begin
              if (count == '0) begin
                resp_next.status = STAT_EMPTY;
              end else begin
                resp_next.status  = STAT_ELEM;
                resp_next.element = cell_data[0];
                resp_next.last    = (count == COUNT_W'(1));
                if (count != COUNT_W'(1)) begin
                  state_next    = S_DUMP;
                  dump_idx_next = IDX_W'(1);
                end
              end
            end
          endcase
          resp_next.count = count_next;
        end
      end
      S_DUMP: begin
        strobe_next             = 1'b1;
        resp_next.status        = STAT_ELEM;
        resp_next.element       = cell_data[0];
        resp_next.element_index = dump_idx;
        resp_next.count         = count;
        resp_next.last          = (dump_idx == last_idx);
        dump_idx_next           = dump_idx + IDX_W'(1);
        if (dump_idx == last_idx) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      dump_idx <= '0;
      strobe   <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      dump_idx <= dump_idx_next;
      strobe   <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    response <= resp_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_busy_nonempty: assert property (@(posedge clk) disable iff (rst)
    busy |-> count != '0)
    else $error("dump in progress on an empty list");

  a_busy_count_stable: assert property (@(posedge clk) disable iff (rst)
    busy |=> $stable(count))
    else $error("count changed during a dump");

  a_busy_strobes: assert property (@(posedge clk) disable iff (rst)
    busy |=> strobe)
    else $error("dump cycle without a result");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (strobe && response.last) |-> !busy)
    else $error("still busy after the final result of an item");

endmodule
